// ===== sv/rcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types and constants of the rgb 3x3 convolution filter: beat
// formats, configuration register indexes and datapath widths.
// ----------------------------------------------------------------------------
package rcf_pkg;

    localparam int KERNEL_SIZE        = 3;
    localparam int COEF_W             = 16;
    localparam int COEF_FRACTION_BITS = 12;
    localparam int CHAN_W             = 8;
    localparam int NUM_CHAN           = 3;
    localparam int PIXEL_W            = NUM_CHAN * CHAN_W;

    // signed coefficient times zero-extended channel, then two adder levels
    localparam int PROD_W    = COEF_W + CHAN_W + 1;
    localparam int ROW_SUM_W = PROD_W + 2;
    localparam int SUM_W     = ROW_SUM_W + 2;

    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 48;
    localparam int SIZE_W          = 11;
    localparam int IMAGE_SIZE_INIT = 1024;

    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_TOP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MIDDLE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_BOTTOM = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;

    // identity kernel: 1.0 in the centre tap
    localparam logic [CFG_DATA_W-1:0] KERNEL_TOP_INIT    = 48'h0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] KERNEL_MIDDLE_INIT = 48'h0000_1000_0000;
    localparam logic [CFG_DATA_W-1:0] KERNEL_BOTTOM_INIT = 48'h0000_0000_0000;

    localparam logic CMD_PIXEL = 1'b0;

    typedef struct packed {
        logic              cmd;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pixel_beat_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              frame_end;
    } result_beat_t;

    // border masks and frame end of one result, index 0 is top row / left column
    typedef struct packed {
        logic                   last;
        logic [KERNEL_SIZE-1:0] row_ok;
        logic [KERNEL_SIZE-1:0] col_ok;
    } tap_ctrl_t;

endpackage

// ===== sv/rgb_3x3_convolution_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_filter_core
// Zero-padded 3x3 convolution of an rgb raster stream with two line stores.
// ----------------------------------------------------------------------------
// Usage
//  pix carries one beat per pixel in raster order (cmd 0), followed by drain
//  beats (cmd 1) that push the last row out. res carries the filtered pixel,
//  frame_end marks the last pixel of the frame. A beat moves when valid is
//  high and stall is low.
//  The result for a pixel is due when the beat one row plus one pixel later
//  is taken; it then passes stages 1 to 4 and the result register to res.
//  Throughput is one beat per cycle while res is not stalled: the two line
//  stores are read and written once per beat, and same-entry overlaps, as
//  for width one, are covered by a forwarding path into the older store.
//  When res is stalled the whole pipeline holds and pix_stall rises.
//  Reset clears counters and valid flags and restores the kernel and image
//  size registers. The line stores are not cleared: every tap that is not
//  masked by the border reads an entry written earlier in the same frame.
//  cfg_we writes register cfg_index; writing the width or height restarts
//  the frame. The user must write only while idle; the block does not check.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_filter_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pix_valid,
    output logic                                 pix_stall,
    input  rcf_pkg::pixel_beat_t                 pix,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output rcf_pkg::result_beat_t                res,
    input  logic                                 cfg_we,
    input  logic [rcf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rcf_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    // room for the input row running two rows past the frame while draining
    localparam int HW = $clog2(MAX_HEIGHT) + 1;
    localparam int WIDTH_INIT  = (MAX_WIDTH < rcf_pkg::IMAGE_SIZE_INIT) ?
                                 MAX_WIDTH : rcf_pkg::IMAGE_SIZE_INIT;
    localparam int HEIGHT_INIT = (MAX_HEIGHT < rcf_pkg::IMAGE_SIZE_INIT) ?
                                 MAX_HEIGHT : rcf_pkg::IMAGE_SIZE_INIT;
    localparam int KS = rcf_pkg::KERNEL_SIZE;
    localparam int NC = rcf_pkg::NUM_CHAN;

    // configuration
    logic [rcf_pkg::CFG_DATA_W-1:0] kernel_reg [KS];
    logic [WW-1:0]                  width_reg;
    logic [HW-1:0]                  height_reg;
    logic [WW-1:0]                  width_eff;
    logic [HW-1:0]                  height_eff;
    logic                           size_write;

    // position counters
    logic [CW-1:0] in_col_reg,  in_col_next;
    logic [HW-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [HW-1:0] out_row_reg, out_row_next;

    // stage 0
    logic                        adv;
    logic                        accept;
    logic [WW-1:0]               col_inc;
    logic                        col_wrap;
    logic                        pix_live;
    logic [rcf_pkg::PIXEL_W-1:0] pix_word;
    logic                        emit;
    logic [WW-1:0]               ocol_inc;
    logic [HW-1:0]               orow_inc;
    logic                        ocol_end;
    logic                        orow_end;
    rcf_pkg::tap_ctrl_t          ctrl;
    logic                        fwd;

    // line stores
    logic [rcf_pkg::PIXEL_W-1:0] older_mem [MAX_WIDTH];
    logic [rcf_pkg::PIXEL_W-1:0] newer_mem [MAX_WIDTH];
    logic [rcf_pkg::PIXEL_W-1:0] older_rd_reg;
    logic [rcf_pkg::PIXEL_W-1:0] newer_rd_reg;

    // stage 1
    logic                        s1_valid_reg;
    logic [CW-1:0]               s1_col_reg;
    logic [rcf_pkg::PIXEL_W-1:0] s1_pix_reg;
    rcf_pkg::tap_ctrl_t          s1_ctrl_reg;
    logic                        s1_emit_reg;
    logic                        s1_fwd_reg;
    logic [rcf_pkg::PIXEL_W-1:0] s1_fwd_data_reg;
    logic [rcf_pkg::PIXEL_W-1:0] above1;
    logic [rcf_pkg::PIXEL_W-1:0] above2;

    // stage 2
    logic [rcf_pkg::PIXEL_W-1:0] window_reg [KS][KS];
    logic                        s2_valid_reg;
    rcf_pkg::tap_ctrl_t          s2_ctrl_reg;
    logic signed [rcf_pkg::PROD_W-1:0] prod [NC][KS][KS];

    // stage 3
    logic                              s3_valid_reg;
    logic                              s3_last_reg;
    logic signed [rcf_pkg::PROD_W-1:0] prod_reg [NC][KS][KS];
    logic signed [rcf_pkg::ROW_SUM_W-1:0] row_sum [NC][KS];

    // stage 4
    logic                                 s4_valid_reg;
    logic                                 s4_last_reg;
    logic signed [rcf_pkg::ROW_SUM_W-1:0] row_sum_reg [NC][KS];
    logic signed [rcf_pkg::SUM_W-1:0]     total [NC];
    logic [rcf_pkg::CHAN_W-1:0]           chan_res [NC];

    logic                  res_valid_reg;
    rcf_pkg::result_beat_t res_reg;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_comb
    begin
        width_eff = WW'(MAX_WIDTH);
        if (cfg_data[rcf_pkg::SIZE_W-1:0] == '0)
            width_eff = WW'(1);
        else if (int'(cfg_data[rcf_pkg::SIZE_W-1:0]) <= MAX_WIDTH)
            width_eff = WW'(cfg_data[rcf_pkg::SIZE_W-1:0]);

        height_eff = HW'(MAX_HEIGHT);
        if (cfg_data[rcf_pkg::SIZE_W-1:0] == '0)
            height_eff = HW'(1);
        else if (int'(cfg_data[rcf_pkg::SIZE_W-1:0]) <= MAX_HEIGHT)
            height_eff = HW'(cfg_data[rcf_pkg::SIZE_W-1:0]);
    end

    assign size_write = cfg_we && ((cfg_index == rcf_pkg::REG_IMAGE_WIDTH) ||
                                   (cfg_index == rcf_pkg::REG_IMAGE_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg[0] <= rcf_pkg::KERNEL_TOP_INIT;
            kernel_reg[1] <= rcf_pkg::KERNEL_MIDDLE_INIT;
            kernel_reg[2] <= rcf_pkg::KERNEL_BOTTOM_INIT;
            width_reg     <= WW'(WIDTH_INIT);
            height_reg    <= HW'(HEIGHT_INIT);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rcf_pkg::REG_KERNEL_TOP:    kernel_reg[0] <= cfg_data;
                rcf_pkg::REG_KERNEL_MIDDLE: kernel_reg[1] <= cfg_data;
                rcf_pkg::REG_KERNEL_BOTTOM: kernel_reg[2] <= cfg_data;
                rcf_pkg::REG_IMAGE_WIDTH:   width_reg     <= width_eff;
                rcf_pkg::REG_IMAGE_HEIGHT:  height_reg    <= height_eff;
                default:                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 0: position bookkeeping and line store access
    // ------------------------------------------------------------------
    assign adv       = !res_valid_reg || !res_stall;
    assign pix_stall = !adv;
    assign accept    = pix_valid && adv;

    assign col_inc  = {1'b0, in_col_reg} + WW'(1);
    assign col_wrap = col_inc >= width_reg;
    assign pix_live = (pix.cmd == rcf_pkg::CMD_PIXEL) && (in_row_reg < height_reg);
    assign pix_word = pix_live ? {pix.blue_in, pix.green_in, pix.red_in} : '0;
    // a result is due once the stream is one row plus one pixel in
    assign emit = (in_row_reg > HW'(1)) || ((in_row_reg == HW'(1)) && (in_col_reg != '0));

    assign ocol_inc = {1'b0, out_col_reg} + WW'(1);
    assign orow_inc = out_row_reg + HW'(1);
    assign ocol_end = ocol_inc >= width_reg;
    assign orow_end = orow_inc >= height_reg;

    assign ctrl.row_ok = {!orow_end, 1'b1, out_row_reg != '0};
    assign ctrl.col_ok = {!ocol_end, 1'b1, out_col_reg != '0};
    assign ctrl.last   = orow_end && ocol_end;

    // the beat in stage 1 writes the older store at this very column now
    assign fwd = s1_valid_reg && (s1_col_reg == in_col_reg);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        priority if (size_write)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + HW'(1);
            end
            else
            begin
                in_col_next = col_inc[CW-1:0];
            end
            if (emit)
            begin
                priority if (ctrl.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (ocol_end)
                begin
                    out_col_next = '0;
                    out_row_next = orow_inc;
                end
                else
                begin
                    out_col_next = ocol_inc[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    assign above1 = newer_rd_reg;
    assign above2 = s1_fwd_reg ? s1_fwd_data_reg : older_rd_reg;

    // newer store takes the pixel at once, older store takes the row moving up
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            older_rd_reg <= older_mem[in_col_reg];
            newer_rd_reg <= newer_mem[in_col_reg];
        end
        if (accept)
            newer_mem[in_col_reg] <= pix_word;
        if (adv && s1_valid_reg)
            older_mem[s1_col_reg] <= above1;
    end

    // ------------------------------------------------------------------
    // stage 1: window shift
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            res_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_col_reg      <= in_col_reg;
            s1_pix_reg      <= pix_word;
            s1_ctrl_reg     <= ctrl;
            s1_emit_reg     <= emit;
            s1_fwd_reg      <= fwd;
            s1_fwd_data_reg <= above1;
            s2_ctrl_reg     <= s1_ctrl_reg;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < KS; r++)
                begin
                    for (int c = 0; c < KS - 1; c++)
                        window_reg[r][c] <= window_reg[r][c+1];
                end
                window_reg[0][KS-1] <= above2;
                window_reg[1][KS-1] <= above1;
                window_reg[2][KS-1] <= s1_pix_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: products, taps outside the image count as zero
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int ch = 0; ch < NC; ch++)
        begin
            for (int r = 0; r < KS; r++)
            begin
                for (int c = 0; c < KS; c++)
                begin
                    if (s2_ctrl_reg.row_ok[r] && s2_ctrl_reg.col_ok[c])
                        prod[ch][r][c] =
                            $signed(kernel_reg[r][rcf_pkg::COEF_W*c +: rcf_pkg::COEF_W]) *
                            $signed({1'b0, window_reg[r][c][rcf_pkg::CHAN_W*ch +: rcf_pkg::CHAN_W]});
                    else
                        prod[ch][r][c] = '0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3 and 4: row sums, total and saturation
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int ch = 0; ch < NC; ch++)
        begin
            for (int r = 0; r < KS; r++)
                row_sum[ch][r] = rcf_pkg::ROW_SUM_W'(prod_reg[ch][r][0])
                               + rcf_pkg::ROW_SUM_W'(prod_reg[ch][r][1])
                               + rcf_pkg::ROW_SUM_W'(prod_reg[ch][r][2]);
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NC; ch++)
        begin
            total[ch] = rcf_pkg::SUM_W'(row_sum_reg[ch][0])
                      + rcf_pkg::SUM_W'(row_sum_reg[ch][1])
                      + rcf_pkg::SUM_W'(row_sum_reg[ch][2]);
            if (total[ch][rcf_pkg::SUM_W-1])
                chan_res[ch] = '0;
            else if (|total[ch][rcf_pkg::SUM_W-2:rcf_pkg::COEF_FRACTION_BITS+rcf_pkg::CHAN_W])
                chan_res[ch] = '1;
            else
                chan_res[ch] = total[ch][rcf_pkg::COEF_FRACTION_BITS +: rcf_pkg::CHAN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg          <= prod;
            s3_last_reg       <= s2_ctrl_reg.last;
            row_sum_reg       <= row_sum;
            s4_last_reg       <= s3_last_reg;
            res_reg.red_out   <= chan_res[0];
            res_reg.green_out <= chan_res[1];
            res_reg.blue_out  <= chan_res[2];
            res_reg.frame_end <= s4_last_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rgb 3x3 convolution filter core. A short table
// of hand-computed frames (identity kernel, early drain, pixels past the end
// of a frame, saturation at both ends) is followed by a wide and a tall frame
// at the size limits. Random frames then run under random kernels and sizes,
// some of them cut short. A bit-accurate model of the window and line stores
// predicts every output beat outside the table. Both ports idle at random,
// and the result port holds off long enough once to back the pipeline up.
// ----------------------------------------------------------------------------
module tb_top;
    import rcf_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int RANDOM_BEATS  = 1450;
    localparam int SETTLE_CYCLES = 8;
    localparam int FINAL_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PRINT_CAP     = 40;

    localparam logic CMD_DRAIN = 1'b1;
    // unmapped register index, writes must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_mode_t;

    typedef struct {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        pixel_beat_t            beat;
        logic                   typed;
        result_beat_t           want;
    } plan_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   pix_valid = 1'b0;
    logic                   pix_stall;
    pixel_beat_t            pix       = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    result_beat_t           res;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // filter model state
    logic [CFG_DATA_W-1:0] kern [3];
    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    logic [PIXEL_W-1:0]    older_line [MAX_W];
    logic [PIXEL_W-1:0]    newer_line [MAX_W];
    logic [PIXEL_W-1:0]    win [9];
    int unsigned           in_col, in_row, out_col, out_row;

    result_beat_t due_results [$];
    plan_row_t    plan [$];

    int unsigned mismatches   = 0;
    int unsigned random_beats = 0;
    int unsigned burst_left   = 0;
    int unsigned cycle_count  = 0;
    int unsigned rx_left      = 0;
    rx_mode_t    rx_mode      = RX_FREE;
    logic        quiet_rx     = 1'b0;
    logic        hold_go      = 1'b0;

    rgb_3x3_convolution_filter_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int unsigned frame_dim(input logic [SIZE_W-1:0] v,
                                              input int unsigned cap);
        if (v == 0)
            return 1;
        return (v > cap) ? cap : int'(v);
    endfunction

    function automatic void rewind_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void apply_config(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_KERNEL_TOP:    kern[0] = d;
            REG_KERNEL_MIDDLE: kern[1] = d;
            REG_KERNEL_BOTTOM: kern[2] = d;
            REG_IMAGE_WIDTH:
            begin
                width_reg = d[SIZE_W-1:0];
                rewind_frame();
            end
            REG_IMAGE_HEIGHT:
            begin
                height_reg = d[SIZE_W-1:0];
                rewind_frame();
            end
            default: ;
        endcase
    endfunction

    // one accepted beat through the line stores and window, plus the
    // filtered pixel it releases, if any
    function automatic void filter_pixel(input pixel_beat_t b, output logic emit,
                                         output result_beat_t r);
        int unsigned        w, h, col, orow, ocol, i, j, ch;
        logic [PIXEL_W-1:0] fresh, above2, above1;
        logic [2:0]         row_ok, col_ok;
        logic signed [15:0] coef;
        longint             acc, tap, q;
        logic [7:0]         chan [3];
        logic               last;
        w = frame_dim(width_reg, MAX_W);
        h = frame_dim(height_reg, MAX_H);
        col = in_col % w;
        fresh = '0;
        if (b.cmd == CMD_PIXEL && in_row < h)
            fresh = {b.blue_in, b.green_in, b.red_in};
        emit = (in_row > 1) || (in_row == 1 && col >= 1);
        above2 = older_line[col];
        above1 = newer_line[col];
        older_line[col] = above1;
        newer_line[col] = fresh;
        for (i = 0; i < 3; i++)
        begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = above2;
        win[5] = above1;
        win[8] = fresh;
        col++;
        if (col >= w)
        begin
            col = 0;
            in_row++;
        end
        in_col = col;
        r = '0;
        if (!emit)
            return;
        orow = out_row;
        ocol = out_col % w;
        // bit 0 is the top row / left column
        row_ok = {orow + 1 < h, 1'b1, orow > 0};
        col_ok = {ocol + 1 < w, 1'b1, ocol > 0};
        for (ch = 0; ch < 3; ch++)
        begin
            acc = 0;
            for (i = 0; i < 3; i++)
                for (j = 0; j < 3; j++)
                    if (row_ok[i] && col_ok[j])
                    begin
                        coef = kern[i][16*j +: 16];
                        tap  = {56'd0, win[i*3+j][8*ch +: 8]};
                        acc += coef * tap;
                    end
            if (acc <= 0)
                chan[ch] = 8'd0;
            else
            begin
                q = acc >>> COEF_FRACTION_BITS;
                chan[ch] = (q > 255) ? 8'hFF : q[7:0];
            end
        end
        last = (orow + 1 >= h) && (ocol + 1 >= w);
        r.red_out   = chan[0];
        r.green_out = chan[1];
        r.blue_out  = chan[2];
        r.frame_end = last;
        if (last)
            rewind_frame();
        else
        begin
            ocol++;
            if (ocol >= w)
            begin
                ocol = 0;
                out_row = orow + 1;
            end
            out_col = ocol;
        end
    endfunction

    function automatic void row_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
        plan_row_t row;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = d;
        row.beat   = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        plan.push_back(row);
    endfunction

    function automatic void row_beat(input logic c, input logic [7:0] r, g, bl);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.idx    = '0;
        row.data   = '0;
        row.beat   = {c, r, g, bl};
        row.typed  = 1'b0;
        row.want   = '0;
        plan.push_back(row);
    endfunction

    function automatic void row_check(input logic c, input logic [7:0] r, g, bl,
                                      input logic [7:0] er, eg, eb, input logic fe);
        row_beat(c, r, g, bl);
        plan[$].typed = 1'b1;
        plan[$].want  = {er, eg, eb, fe};
    endfunction

    function automatic logic [7:0] pick_chan();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_dim(input int unsigned common_hi,
                                                   input int unsigned rare_hi);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return '0;
        if (roll < 75)
            return SIZE_W'($urandom_range(1, common_hi));
        return SIZE_W'($urandom_range(common_hi + 1, rare_hi));
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t ns  %s: got %02h, expected %02h", $time, what, got, want);
        mismatches++;
    endtask

    // registers change only with nothing in flight
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        pix_valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        quiet_rx = 1'b1;
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        apply_config(idx, d);
        quiet_rx = 1'b0;
    endtask

    // junk above the size field must be ignored
    task automatic write_size(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [SIZE_W-1:0] v);
        logic [CFG_DATA_W-1:0] d;
        d = {16'($urandom), 32'($urandom)};
        d[SIZE_W-1:0] = v;
        cfg_write(idx, d);
    endtask

    task automatic load_kernel();
        logic [15:0]           k [9];
        logic [CFG_DATA_W-1:0] rowv [3];
        int unsigned           style, i;
        style = $urandom_range(0, 5);
        for (i = 0; i < 9; i++)
            case (style)
                0: k[i] = 16'($urandom);
                1: k[i] = 16'($urandom_range(0, 'h0800));
                2: k[i] = (i == 4) ? 16'h5000 : (i % 2 == 1) ? 16'hF000 : 16'h0000;
                3: k[i] = (i == 4) ? 16'h7FFF : 16'hF000;
                4:
                    case ($urandom_range(0, 4))
                        0:       k[i] = 16'h7FFF;
                        1:       k[i] = 16'h8000;
                        2:       k[i] = 16'h0000;
                        3:       k[i] = 16'hFFFF;
                        default: k[i] = 16'h0001;
                    endcase
                default: k[i] = 16'($urandom_range(0, 'h2000)) - 16'h1000;
            endcase
        for (i = 0; i < 3; i++)
            rowv[i] = {k[i*3+2], k[i*3+1], k[i*3]};
        cfg_write(REG_KERNEL_TOP, rowv[0]);
        cfg_write(REG_KERNEL_MIDDLE, rowv[1]);
        cfg_write(REG_KERNEL_BOTTOM, rowv[2]);
    endtask

    // offers one beat, with a random gap between bursts, and books its result
    task automatic send_beat(input pixel_beat_t b, input logic typed,
                             input result_beat_t want);
        logic         emit;
        result_beat_t guess;
        if (burst_left == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 200)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        pix       <= b;
        pix_valid <= 1'b1;
        do
            @(posedge clk);
        while (pix_stall);
        filter_pixel(b, emit, guess);
        if (emit || typed)
            due_results.push_back(typed ? want : guess);
        @(negedge clk);
    endtask

    // a whole frame plus the drain beats behind it, or a cut-off part of one
    task automatic send_frame(input logic cut);
        int unsigned w, h, n, total;
        pixel_beat_t b;
        w = frame_dim(width_reg, MAX_W);
        h = frame_dim(height_reg, MAX_H);
        total = w * h + w + 1;
        if (cut)
            total = $urandom_range(1, total - 1);
        for (n = 0; n < total; n++)
        begin
            b.red_in   = pick_chan();
            b.green_in = pick_chan();
            b.blue_in  = pick_chan();
            if (n < w * h)
                b.cmd = ($urandom_range(0, 19) == 0) ? CMD_DRAIN : CMD_PIXEL;
            else
                b.cmd = ($urandom_range(0, 9) < 4) ? CMD_PIXEL : CMD_DRAIN;
            send_beat(b, 1'b0, '0);
            random_beats++;
        end
    endtask

    always @(negedge clk)
    begin : result_backpressure
        logic hold;
        if (rx_left == 0)
        begin
            if (hold_go)
            begin
                rx_mode = RX_HOLD;
                rx_left = 300;
                hold_go = 1'b0;
            end
            else if ($urandom_range(0, 30) == 0)
            begin
                rx_mode = RX_HOLD;
                rx_left = $urandom_range(40, 120);
            end
            else
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_left = $urandom_range(8, 120);
            end
        end
        else
            rx_left--;
        case (rx_mode)
            RX_FREE:  hold = 1'b0;
            RX_LIGHT: hold = ($urandom_range(0, 3) == 0);
            RX_HEAVY: hold = ($urandom_range(0, 3) != 0);
            default:  hold = 1'b1;
        endcase
        res_stall <= hold && !quiet_rx;
    end

    always @(posedge clk)
    begin : result_check
        result_beat_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (due_results.size() == 0)
                flag_mismatch("result beat with nothing due, red", res.red_out, 8'h00);
            else
            begin
                want = due_results.pop_front();
                if (res.red_out !== want.red_out)
                    flag_mismatch("red_out", res.red_out, want.red_out);
                if (res.green_out !== want.green_out)
                    flag_mismatch("green_out", res.green_out, want.green_out);
                if (res.blue_out !== want.blue_out)
                    flag_mismatch("blue_out", res.blue_out, want.blue_out);
                if (res.frame_end !== want.frame_end)
                    flag_mismatch("frame_end", {7'd0, res.frame_end}, {7'd0, want.frame_end});
            end
        end
    end

    initial
    begin
        int unsigned i;
        kern[0]    = KERNEL_TOP_INIT;
        kern[1]    = KERNEL_MIDDLE_INIT;
        kern[2]    = KERNEL_BOTTOM_INIT;
        width_reg  = SIZE_W'(IMAGE_SIZE_INIT);
        height_reg = SIZE_W'(IMAGE_SIZE_INIT);
        for (i = 0; i < MAX_W; i++)
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        for (i = 0; i < 9; i++)
            win[i] = '0;
        rewind_frame();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 2x2 frame, reset kernel is the identity
        row_cfg(REG_IMAGE_WIDTH, 48'd2);
        row_cfg(REG_IMAGE_HEIGHT, 48'd2);
        row_beat(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
        row_beat(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        row_beat(CMD_PIXEL, 8'h12, 8'h34, 8'h56);
        row_check(CMD_PIXEL, 8'hA5, 8'h5A, 8'h81, 8'h00, 8'h00, 8'h00, 1'b0);
        row_check(CMD_DRAIN, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        row_check(CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 1'b0);
        row_check(CMD_DRAIN, 8'h3C, 8'hC3, 8'h00, 8'hA5, 8'h5A, 8'h81, 1'b1);
        // early drain reads as black, pixels past the frame act as drains
        row_beat(CMD_PIXEL, 8'h11, 8'h22, 8'h33);
        row_beat(CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF);
        row_beat(CMD_PIXEL, 8'h44, 8'h55, 8'h66);
        row_check(CMD_PIXEL, 8'h77, 8'h88, 8'h99, 8'h11, 8'h22, 8'h33, 1'b0);
        row_check(CMD_PIXEL, 8'hEE, 8'hEE, 8'hEE, 8'h00, 8'h00, 8'h00, 1'b0);
        row_check(CMD_PIXEL, 8'hCC, 8'hCC, 8'hCC, 8'h44, 8'h55, 8'h66, 1'b0);
        row_check(CMD_DRAIN, 8'h5A, 8'hA5, 8'h3C, 8'h77, 8'h88, 8'h99, 1'b1);
        // largest positive taps saturate high
        row_cfg(REG_KERNEL_TOP, 48'h7FFF_7FFF_7FFF);
        row_cfg(REG_KERNEL_MIDDLE, 48'h7FFF_7FFF_7FFF);
        row_cfg(REG_KERNEL_BOTTOM, 48'h7FFF_7FFF_7FFF);
        row_cfg(REG_IMAGE_WIDTH, 48'd2);
        row_cfg(REG_IMAGE_HEIGHT, 48'd1);
        row_beat(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        row_beat(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        row_beat(CMD_DRAIN, 8'h00, 8'h00, 8'h00);
        row_check(CMD_DRAIN, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        row_check(CMD_DRAIN, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // most negative taps clamp to zero
        row_cfg(REG_KERNEL_TOP, 48'h8000_8000_8000);
        row_cfg(REG_KERNEL_MIDDLE, 48'h8000_8000_8000);
        row_cfg(REG_KERNEL_BOTTOM, 48'h8000_8000_8000);
        row_cfg(REG_SPARE, 48'hFFFF_FFFF_FFFF);
        row_beat(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        row_beat(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        row_beat(CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF);
        row_check(CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
        row_check(CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);

        foreach (plan[n])
        begin
            if (plan[n].is_cfg)
                cfg_write(plan[n].idx, plan[n].data);
            else
                send_beat(plan[n].beat, plan[n].typed, plan[n].want);
        end

        // widest frame: oversize width saturates, zero height acts as one row
        load_kernel();
        write_size(REG_IMAGE_WIDTH, SIZE_W'($urandom_range(MAX_W + 1, 2047)));
        write_size(REG_IMAGE_HEIGHT, '0);
        send_frame(1'b0);

        // tallest frame, with one long hold-off on the result side
        load_kernel();
        write_size(REG_IMAGE_WIDTH, '0);
        write_size(REG_IMAGE_HEIGHT, SIZE_W'($urandom_range(MAX_H + 1, 2047)));
        hold_go = 1'b1;
        send_frame(1'b0);

        random_beats = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 9) != 0)
                load_kernel();
            if ($urandom_range(0, 9) != 0)
            begin
                write_size(REG_IMAGE_WIDTH, pick_dim(6, 32));
                write_size(REG_IMAGE_HEIGHT, pick_dim(5, 12));
            end
            repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 7) == 0);
        end

        pix_valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        quiet_rx = 1'b1;
        repeat (FINAL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rcf_pkg.sv
sv/rgb_3x3_convolution_filter_core.sv
tb/tb_top.sv
